// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

  localparam int QUEUE_DEPTH = 4;

  // result status codes
  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // parser modes
  localparam logic [2:0] MODE_TEXT    = 3'd0;
  localparam logic [2:0] MODE_ESC     = 3'd1;
  localparam logic [2:0] MODE_HEX1    = 3'd2;
  localparam logic [2:0] MODE_HEX2    = 3'd3;
  localparam logic [2:0] MODE_HEX3    = 3'd4;
  localparam logic [2:0] MODE_HEX4    = 3'd5;
  localparam logic [2:0] MODE_SWALLOW = 3'd6;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U         = 8'h75;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_end;
  } jsu_out_t;

  // all results caused by one input word: data bytes, then an optional tail
  typedef struct packed {
    logic [1:0]      nbytes;
    logic            has_tail;
    logic [1:0]      tail;
    logic [2:0][7:0] bytes;
  } jsu_bundle_t;

  // {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // {valid, byte}
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h22:   r = {1'b1, 8'h22};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h2F:   r = {1'b1, 8'h2F};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/jsu_front.sv =====
module jsu_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  jsu_pkg::jsu_in_t     item,
  input  logic                 q_full,
  output logic                 q_wr,
  output jsu_pkg::jsu_bundle_t q_data
);

  logic [2:0]  mode, mode_next;
  logic [11:0] acc, acc_next;
  logic        accept;
  logic        err;
  logic [8:0]  esc;
  logic [4:0]  hv;
  logic [15:0] cp;
  logic [7:0]  c;
  logic        last;

  assign accept = push && !q_full;
  assign c      = item.in_byte;
  assign last   = item.last_byte;
  assign esc    = jsu_pkg::simple_escape(c);
  assign hv     = jsu_pkg::hex_value(c);
  assign cp     = {acc, hv[3:0]};

  always_comb begin
    mode_next       = mode;
    acc_next        = acc;
    err             = 1'b0;
    q_data          = '0;
    q_data.tail     = jsu_pkg::ST_DATA;
    if (mode == jsu_pkg::MODE_SWALLOW) begin
      // drop everything up to the end of the stream
      if (last) begin
        mode_next = jsu_pkg::MODE_TEXT;
        acc_next  = '0;
      end
    end else begin
      if (mode == jsu_pkg::MODE_ESC) begin
        if (esc[8]) begin
          q_data.nbytes   = 2'd1;
          q_data.bytes[0] = esc[7:0];
          mode_next       = jsu_pkg::MODE_TEXT;
        end else if (c == jsu_pkg::CH_U) begin
          acc_next  = '0;
          mode_next = jsu_pkg::MODE_HEX1;
        end else begin
          err = 1'b1;
        end
      end else if (mode >= jsu_pkg::MODE_HEX1 && mode <= jsu_pkg::MODE_HEX4) begin
        if (!hv[4]) begin
          err = 1'b1;
        end else if (mode != jsu_pkg::MODE_HEX4) begin
          acc_next  = {acc[7:0], hv[3:0]};
          mode_next = mode + 3'd1;
        end else begin
          acc_next  = '0;
          mode_next = jsu_pkg::MODE_TEXT;
          if (cp[15:11] == 5'b11011) begin
            err = 1'b1;
          end else if (cp[15:7] == '0) begin
            q_data.nbytes   = 2'd1;
            q_data.bytes[0] = cp[7:0];
          end else if (cp[15:11] == '0) begin
            q_data.nbytes   = 2'd2;
            q_data.bytes[0] = {3'b110, cp[10:6]};
            q_data.bytes[1] = {2'b10, cp[5:0]};
          end else begin
            q_data.nbytes   = 2'd3;
            q_data.bytes[0] = {4'b1110, cp[15:12]};
            q_data.bytes[1] = {2'b10, cp[11:6]};
            q_data.bytes[2] = {2'b10, cp[5:0]};
          end
        end
      end else begin
        mode_next = jsu_pkg::MODE_TEXT;
        if (c == jsu_pkg::CH_BACKSLASH) begin
          mode_next = jsu_pkg::MODE_ESC;
        end else begin
          q_data.nbytes   = 2'd1;
          q_data.bytes[0] = c;
        end
      end

      // stream ends inside an escape
      if (last && mode_next != jsu_pkg::MODE_TEXT) begin
        err = 1'b1;
      end

      if (err) begin
        q_data.nbytes   = 2'd0;
        q_data.has_tail = 1'b1;
        q_data.tail     = jsu_pkg::ST_ERROR;
        mode_next       = last ? jsu_pkg::MODE_TEXT : jsu_pkg::MODE_SWALLOW;
        acc_next        = '0;
      end else if (last) begin
        q_data.has_tail = 1'b1;
        q_data.tail     = jsu_pkg::ST_DONE;
        mode_next       = jsu_pkg::MODE_TEXT;
        acc_next        = '0;
      end
    end
  end

  assign q_wr = accept && (q_data.has_tail || q_data.nbytes != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= jsu_pkg::MODE_TEXT;
      acc  <= '0;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
    end
  end

endmodule

// ===== rtl/jsu_fifo.sv =====
module jsu_fifo #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  jsu_pkg::jsu_bundle_t wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output jsu_pkg::jsu_bundle_t rd_data,
  output logic                 empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  jsu_pkg::jsu_bundle_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/jsu_back.sv =====
module jsu_back (
  input  logic                 clk,
  input  logic                 rst,
  input  jsu_pkg::jsu_bundle_t head,
  input  logic                 q_empty,
  output logic                 q_rd,
  input  logic                 pop,
  output logic                 empty,
  output jsu_pkg::jsu_out_t    result
);

  logic [1:0] pos;
  logic [2:0] total;
  logic       is_last;
  logic       take;

  assign empty   = q_empty;
  assign total   = {1'b0, head.nbytes} + {2'b00, head.has_tail};
  assign is_last = ({1'b0, pos} + 3'd1) == total;
  assign take    = pop && !q_empty;
  assign q_rd    = take && is_last;

  always_comb begin
    result.run_end = is_last;
    if ({1'b0, pos} < {1'b0, head.nbytes}) begin
      result.status = jsu_pkg::ST_DATA;
      unique case (pos)
        2'd0:    result.out_byte = head.bytes[0];
        2'd1:    result.out_byte = head.bytes[1];
        default: result.out_byte = head.bytes[2];
      endcase
    end else begin
      result.status   = head.tail;
      result.out_byte = 8'd0;
    end
  end

  // advance through the head bundle, release it after its last result
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (take) begin
      pos <= is_last ? 2'd0 : pos + 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> ({1'b0, pos} < total))
    else $error("result index beyond bundle");

  a_hold_bundle: assert property (@(posedge clk) disable iff (rst)
    (take && !is_last) |=> !q_empty)
    else $error("bundle released before its last result");

  a_tail_ends_run: assert property (@(posedge clk) disable iff (rst)
    (!q_empty && result.status != jsu_pkg::ST_DATA) |-> result.run_end)
    else $error("done or error result not last of its run");
`endif

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// Channel  | Handshake          | Word
// ---------+--------------------+-----------------------------------------
// input    | push / full        | item:   in_byte, last_byte
// result   | pop / empty        | result: out_byte, status, run_end
//
// One input word per cycle while full is low. Each word is decoded in its
// accept cycle into a bundle of up to four results, queued in a DEPTH-entry
// bundle queue. The result side drains one result per cycle from the queue
// head while pop is high; a bundle leaves the queue with its last result.
// full depends only on queue occupancy; a stalled result side fills the queue.
// Synchronous reset returns the parser to plain text and empties the queue.
module json_string_unescape_utf8 #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  jsu_pkg::jsu_in_t  item,
  output logic              empty,
  input  logic              pop,
  output jsu_pkg::jsu_out_t result
);

  jsu_pkg::jsu_bundle_t wr_bundle, head;
  logic                 q_wr, q_rd, q_full, q_empty;

  assign full = q_full;

  jsu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_data (wr_bundle)
  );

  jsu_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (wr_bundle),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (head),
    .empty   (q_empty)
  );

  jsu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule
